// ----- design/lcsq_pkg.sv -----
`default_nettype none

package lcsq_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned ROT_W   = 2;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // request opcodes
    localparam logic [OP_W-1:0] OP_SET_WINDOW   = 3'd0;
    localparam logic [OP_W-1:0] OP_DRAW_PIXEL   = 3'd1;
    localparam logic [OP_W-1:0] OP_BEGIN_STREAM = 3'd2;
    localparam logic [OP_W-1:0] OP_STREAM_PIXEL = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_ROTATION = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 1'd1;

    // controller commands
    localparam logic [BYTE_W-1:0] CMD_COL_SET    = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEM_WRITE  = 8'h2C;
    localparam logic [BYTE_W-1:0] CMD_MEM_ACCESS = 8'h36;

    localparam logic [BYTE_W-1:0] MAD_MY = 8'h80;
    localparam logic [BYTE_W-1:0] MAD_MX = 8'h40;
    localparam logic [BYTE_W-1:0] MAD_MV = 8'h20;

    localparam logic [BYTE_W-1:0] MADCTL_TABLE [4] = '{
        MAD_MX | MAD_MY,
        MAD_MY | MAD_MV,
        8'h00,
        MAD_MX | MAD_MV
    };

    // byte counts of each job kind
    localparam logic [IDX_W-1:0] NB_WINDOW = 4'd10;
    localparam logic [IDX_W-1:0] NB_PIXEL  = 4'd9;
    localparam logic [IDX_W-1:0] NB_BEGIN  = 4'd1;
    localparam logic [IDX_W-1:0] NB_STREAM = 4'd2;
    localparam logic [IDX_W-1:0] NB_ROTATE = 4'd2;

    typedef enum logic [2:0] {
        KIND_WINDOW,
        KIND_PIXEL,
        KIND_BEGIN,
        KIND_STREAM,
        KIND_ROTATE
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] area_width;
        logic [COORD_W-1:0] area_height;
        logic [COORD_W-1:0] pixel_color;
        logic               last_pixel;
        logic [ROT_W-1:0]   rotation;
    } t_req;

    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] ye;
        logic [COORD_W-1:0] color;
        logic               last_pixel;
        logic [BYTE_W-1:0]  madctl;
    } t_job;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_command;
        logic              frame_start;
        logic              frame_end;
        logic              last;
    } t_beat;

endpackage

`default_nettype wire

// ----- design/lcd_command_byte_sequencer.sv -----
`default_nettype none

// Byte sequencer for a serial TFT LCD controller.
// Request channel: i_in_valid / o_in_stall with opcode and operands; a beat is
// taken at a clock edge with valid high and stall low. Stream pixels with no
// open frame and unused opcodes are taken and produce nothing.
// Byte channel: o_out_valid / i_out_stall carrying one link byte per beat with
// its command flag, chip-select frame marks and a last flag on the final byte
// of each request.
// Config: i_cfg_we writes the column offset (index 0) or row offset (index 1).
// With the queue empty, a taken request is written into the queue and its first
// byte is then loaded into the output byte register.
// Throughput: one byte per cycle while i_out_stall is low, set by the single
// output byte register. A request has 1 byte for begin stream, 2 for stream
// pixel and set rotation, 9 for draw pixel, 10 for set window.
// A queue of QUEUE_DEPTH decoded requests lets the request side keep going
// while the byte side is stalled; o_in_stall rises only when that queue fills.
// A stalled byte holds in place. Reset clears the queue, the open-frame flag
// and both offsets.
module lcd_command_byte_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [lcsq_pkg::OP_W-1:0]           i_opcode,
    input  wire logic [lcsq_pkg::COORD_W-1:0]        i_pos_x,
    input  wire logic [lcsq_pkg::COORD_W-1:0]        i_pos_y,
    input  wire logic [lcsq_pkg::COORD_W-1:0]        i_area_width,
    input  wire logic [lcsq_pkg::COORD_W-1:0]        i_area_height,
    input  wire logic [lcsq_pkg::COORD_W-1:0]        i_pixel_color,
    input  wire logic                                i_last_pixel,
    input  wire logic [lcsq_pkg::ROT_W-1:0]          i_rotation,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [lcsq_pkg::BYTE_W-1:0]              o_out_byte,
    output logic                                     o_is_command,
    output logic                                     o_frame_start,
    output logic                                     o_frame_end,
    output logic                                     o_last,
    input  wire logic                                i_cfg_we,
    input  wire logic [lcsq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lcsq_pkg::COORD_W-1:0]        i_cfg_data
);

    lcsq_pkg::t_req  req;
    lcsq_pkg::t_job  push_job;
    lcsq_pkg::t_job  head_job;
    lcsq_pkg::t_beat beat;
    logic            push;
    logic            full;
    logic            pop;
    logic            head_valid;

    assign req.opcode      = i_opcode;
    assign req.pos_x       = i_pos_x;
    assign req.pos_y       = i_pos_y;
    assign req.area_width  = i_area_width;
    assign req.area_height = i_area_height;
    assign req.pixel_color = i_pixel_color;
    assign req.last_pixel  = i_last_pixel;
    assign req.rotation    = i_rotation;

    lcsq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    lcsq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_job)
    );

    lcsq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_beat       (beat)
    );

    assign o_out_byte    = beat.out_byte;
    assign o_is_command  = beat.is_command;
    assign o_frame_start = beat.frame_start;
    assign o_frame_end   = beat.frame_end;
    assign o_last        = beat.last;

endmodule

`default_nettype wire

// ----- design/lcsq_front.sv -----
`default_nettype none

module lcsq_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire lcsq_pkg::t_req                    i_req,
    input  wire logic                              i_cfg_we,
    input  wire logic [lcsq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lcsq_pkg::COORD_W-1:0]      i_cfg_data,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output lcsq_pkg::t_job                         o_job
);

    logic [lcsq_pkg::COORD_W-1:0] r_col_off;
    logic [lcsq_pkg::COORD_W-1:0] r_row_off;
    logic                         r_open;
    logic                         n_open;
    logic                         accept;
    logic                         cls_push;
    logic [lcsq_pkg::COORD_W-1:0] xs;
    logic [lcsq_pkg::COORD_W-1:0] ys;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    assign xs = lcsq_pkg::COORD_W'(i_req.pos_x + r_col_off);
    assign ys = lcsq_pkg::COORD_W'(i_req.pos_y + r_row_off);

    always_comb begin
        cls_push         = 1'b0;
        n_open           = r_open;
        o_job.kind       = lcsq_pkg::KIND_WINDOW;
        o_job.xs         = xs;
        o_job.xe         = lcsq_pkg::COORD_W'(xs + i_req.area_width - 16'd1);
        o_job.ys         = ys;
        o_job.ye         = lcsq_pkg::COORD_W'(ys + i_req.area_height - 16'd1);
        o_job.color      = i_req.pixel_color;
        o_job.last_pixel = i_req.last_pixel;
        o_job.madctl     = lcsq_pkg::MADCTL_TABLE[i_req.rotation];
        case (i_req.opcode)
            lcsq_pkg::OP_SET_WINDOW: begin
                cls_push = 1'b1;
                n_open   = 1'b0;
            end
            lcsq_pkg::OP_DRAW_PIXEL: begin
                cls_push   = 1'b1;
                n_open     = 1'b0;
                o_job.kind = lcsq_pkg::KIND_PIXEL;
            end
            lcsq_pkg::OP_BEGIN_STREAM: begin
                cls_push   = 1'b1;
                n_open     = 1'b1;
                o_job.kind = lcsq_pkg::KIND_BEGIN;
            end
            lcsq_pkg::OP_STREAM_PIXEL: begin
                // a pixel with no open frame is dropped
                cls_push   = r_open;
                o_job.kind = lcsq_pkg::KIND_STREAM;
                if (r_open && i_req.last_pixel) begin
                    n_open = 1'b0;
                end
            end
            lcsq_pkg::OP_SET_ROTATION: begin
                cls_push   = 1'b1;
                n_open     = 1'b0;
                o_job.kind = lcsq_pkg::KIND_ROTATE;
            end
            default: begin
                cls_push = 1'b0;
            end
        endcase
    end

    assign o_push = accept && cls_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_col_off <= '0;
            r_row_off <= '0;
        end else begin
            if (accept) begin
                r_open <= n_open;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lcsq_pkg::CFG_COLUMN_OFFSET: r_col_off <= i_cfg_data;
                    lcsq_pkg::CFG_ROW_OFFSET:    r_row_off <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_drop_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.opcode == lcsq_pkg::OP_STREAM_PIXEL && !r_open) |-> !o_push)
        else $error("stream pixel queued with no open frame");

endmodule

`default_nettype wire

// ----- design/lcsq_queue.sv -----
`default_nettype none

module lcsq_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lcsq_pkg::t_job  i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_head_valid,
    output lcsq_pkg::t_job       o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    lcsq_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : PTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : PTR_W'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- design/lcsq_back.sv -----
`default_nettype none

module lcsq_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_head_valid,
    input  wire lcsq_pkg::t_job  i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output lcsq_pkg::t_beat      o_beat
);

    logic [lcsq_pkg::IDX_W-1:0] r_idx;
    logic                       r_out_valid;
    lcsq_pkg::t_beat            r_beat;
    lcsq_pkg::t_beat            n_beat;
    logic [lcsq_pkg::IDX_W-1:0] nbytes;
    logic                       load;
    logic                       is_last;

    // byte generator for the job at the queue head
    always_comb begin
        n_beat = '0;
        nbytes = lcsq_pkg::NB_BEGIN;
        case (i_head.kind)
            lcsq_pkg::KIND_WINDOW: begin
                nbytes = lcsq_pkg::NB_WINDOW;
                case (r_idx)
                    4'd0: begin
                        n_beat.out_byte    = lcsq_pkg::CMD_COL_SET;
                        n_beat.is_command  = 1'b1;
                        n_beat.frame_start = 1'b1;
                    end
                    4'd1: n_beat.out_byte = i_head.xs[15:8];
                    4'd2: n_beat.out_byte = i_head.xs[7:0];
                    4'd3: n_beat.out_byte = i_head.xe[15:8];
                    4'd4: begin
                        n_beat.out_byte  = i_head.xe[7:0];
                        n_beat.frame_end = 1'b1;
                    end
                    4'd5: begin
                        n_beat.out_byte    = lcsq_pkg::CMD_ROW_SET;
                        n_beat.is_command  = 1'b1;
                        n_beat.frame_start = 1'b1;
                    end
                    4'd6: n_beat.out_byte = i_head.ys[15:8];
                    4'd7: n_beat.out_byte = i_head.ys[7:0];
                    4'd8: n_beat.out_byte = i_head.ye[15:8];
                    default: begin
                        n_beat.out_byte  = i_head.ye[7:0];
                        n_beat.frame_end = 1'b1;
                    end
                endcase
            end
            lcsq_pkg::KIND_PIXEL: begin
                nbytes = lcsq_pkg::NB_PIXEL;
                case (r_idx)
                    4'd0: begin
                        n_beat.out_byte    = lcsq_pkg::CMD_COL_SET;
                        n_beat.is_command  = 1'b1;
                        n_beat.frame_start = 1'b1;
                    end
                    4'd1: n_beat.out_byte = i_head.xs[15:8];
                    4'd2: n_beat.out_byte = i_head.xs[7:0];
                    4'd3: begin
                        n_beat.out_byte   = lcsq_pkg::CMD_ROW_SET;
                        n_beat.is_command = 1'b1;
                    end
                    4'd4: n_beat.out_byte = i_head.ys[15:8];
                    4'd5: n_beat.out_byte = i_head.ys[7:0];
                    4'd6: begin
                        n_beat.out_byte   = lcsq_pkg::CMD_MEM_WRITE;
                        n_beat.is_command = 1'b1;
                    end
                    4'd7: n_beat.out_byte = i_head.color[15:8];
                    default: begin
                        n_beat.out_byte  = i_head.color[7:0];
                        n_beat.frame_end = 1'b1;
                    end
                endcase
            end
            lcsq_pkg::KIND_BEGIN: begin
                nbytes             = lcsq_pkg::NB_BEGIN;
                n_beat.out_byte    = lcsq_pkg::CMD_MEM_WRITE;
                n_beat.is_command  = 1'b1;
                n_beat.frame_start = 1'b1;
            end
            lcsq_pkg::KIND_STREAM: begin
                nbytes = lcsq_pkg::NB_STREAM;
                if (r_idx == '0) begin
                    n_beat.out_byte = i_head.color[15:8];
                end else begin
                    n_beat.out_byte  = i_head.color[7:0];
                    n_beat.frame_end = i_head.last_pixel;
                end
            end
            lcsq_pkg::KIND_ROTATE: begin
                nbytes = lcsq_pkg::NB_ROTATE;
                if (r_idx == '0) begin
                    n_beat.out_byte    = lcsq_pkg::CMD_MEM_ACCESS;
                    n_beat.is_command  = 1'b1;
                    n_beat.frame_start = 1'b1;
                end else begin
                    n_beat.out_byte  = i_head.madctl;
                    n_beat.frame_end = 1'b1;
                end
            end
            default: begin
                nbytes = lcsq_pkg::NB_BEGIN;
            end
        endcase
        is_last     = (r_idx == lcsq_pkg::IDX_W'(nbytes - 1'b1));
        n_beat.last = is_last;
    end

    assign load  = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = load && is_last;

    assign o_out_valid = r_out_valid;
    assign o_beat      = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? '0 : lcsq_pkg::IDX_W'(r_idx + 1'b1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= n_beat;
        end
    end

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == '0))
        else $error("byte index not restarted after job");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> i_head_valid)
        else $error("job left the queue mid-sequence");

endmodule

`default_nettype wire

// ----- tb/sv/tb_lcd_command_byte_sequencer.sv -----
`timescale 1ns / 100ps

module tb_lcd_command_byte_sequencer;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [lcsq_pkg::OP_W-1:0]      i_opcode;
    logic [lcsq_pkg::COORD_W-1:0]   i_pos_x;
    logic [lcsq_pkg::COORD_W-1:0]   i_pos_y;
    logic [lcsq_pkg::COORD_W-1:0]   i_area_width;
    logic [lcsq_pkg::COORD_W-1:0]   i_area_height;
    logic [lcsq_pkg::COORD_W-1:0]   i_pixel_color;
    logic                           i_last_pixel;
    logic [lcsq_pkg::ROT_W-1:0]     i_rotation;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [lcsq_pkg::BYTE_W-1:0]    o_out_byte;
    logic                           o_is_command;
    logic                           o_frame_start;
    logic                           o_frame_end;
    logic                           o_last;
    logic                           i_cfg_we;
    logic [lcsq_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [lcsq_pkg::COORD_W-1:0]   i_cfg_data;

    // predicted link bytes, oldest first
    lcsq_pkg::t_beat              pending_bytes[$];
    logic [lcsq_pkg::COORD_W-1:0] col_ofs = '0;
    logic [lcsq_pkg::COORD_W-1:0] row_ofs = '0;
    logic                         frame_open = 1'b0;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int errors = 0;

    lcd_command_byte_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_area_width  (i_area_width),
        .i_area_height (i_area_height),
        .i_pixel_color (i_pixel_color),
        .i_last_pixel  (i_last_pixel),
        .i_rotation    (i_rotation),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_is_command  (o_is_command),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void put_byte(input logic [lcsq_pkg::BYTE_W-1:0] data,
                                     input logic cmd, input logic fstart,
                                     input logic fend);
        lcsq_pkg::t_beat b;
        b.out_byte    = data;
        b.is_command  = cmd;
        b.frame_start = fstart;
        b.frame_end   = fend;
        b.last        = 1'b0;
        pending_bytes.push_back(b);
    endfunction

    function automatic void put_word(input logic [lcsq_pkg::COORD_W-1:0] word,
                                     input logic fend);
        put_byte(word[15:8], 1'b0, 1'b0, 1'b0);
        put_byte(word[7:0], 1'b0, 1'b0, fend);
    endfunction

    // expands one taken request into its link bytes, returns how many
    function automatic int expand_request(input lcsq_pkg::t_req r);
        logic [lcsq_pkg::COORD_W-1:0] xs;
        logic [lcsq_pkg::COORD_W-1:0] ys;
        logic [lcsq_pkg::COORD_W-1:0] xe;
        logic [lcsq_pkg::COORD_W-1:0] ye;
        logic [lcsq_pkg::BYTE_W-1:0]  mad;
        int base;
        base = pending_bytes.size();
        xs = r.pos_x + col_ofs;
        ys = r.pos_y + row_ofs;
        xe = xs + r.area_width - 16'd1;
        ye = ys + r.area_height - 16'd1;
        case (r.opcode)
            lcsq_pkg::OP_SET_WINDOW: begin
                frame_open = 1'b0;
                put_byte(lcsq_pkg::CMD_COL_SET, 1'b1, 1'b1, 1'b0);
                put_word(xs, 1'b0);
                put_word(xe, 1'b1);
                put_byte(lcsq_pkg::CMD_ROW_SET, 1'b1, 1'b1, 1'b0);
                put_word(ys, 1'b0);
                put_word(ye, 1'b1);
            end
            lcsq_pkg::OP_DRAW_PIXEL: begin
                frame_open = 1'b0;
                put_byte(lcsq_pkg::CMD_COL_SET, 1'b1, 1'b1, 1'b0);
                put_word(xs, 1'b0);
                put_byte(lcsq_pkg::CMD_ROW_SET, 1'b1, 1'b0, 1'b0);
                put_word(ys, 1'b0);
                put_byte(lcsq_pkg::CMD_MEM_WRITE, 1'b1, 1'b0, 1'b0);
                put_word(r.pixel_color, 1'b1);
            end
            lcsq_pkg::OP_BEGIN_STREAM: begin
                frame_open = 1'b1;
                put_byte(lcsq_pkg::CMD_MEM_WRITE, 1'b1, 1'b1, 1'b0);
            end
            lcsq_pkg::OP_STREAM_PIXEL: begin
                // dropped when no frame is open
                if (frame_open) begin
                    put_word(r.pixel_color, r.last_pixel);
                    if (r.last_pixel) frame_open = 1'b0;
                end
            end
            lcsq_pkg::OP_SET_ROTATION: begin
                frame_open = 1'b0;
                case (r.rotation)
                    2'd0:    mad = lcsq_pkg::MAD_MX | lcsq_pkg::MAD_MY;
                    2'd1:    mad = lcsq_pkg::MAD_MY | lcsq_pkg::MAD_MV;
                    2'd2:    mad = 8'h00;
                    default: mad = lcsq_pkg::MAD_MX | lcsq_pkg::MAD_MV;
                endcase
                put_byte(lcsq_pkg::CMD_MEM_ACCESS, 1'b1, 1'b1, 1'b0);
                put_byte(mad, 1'b0, 1'b0, 1'b1);
            end
            default: ;
        endcase
        if (pending_bytes.size() > base) pending_bytes[$].last = 1'b1;
        return pending_bytes.size() - base;
    endfunction

    function automatic lcsq_pkg::t_req mk_req(input logic [lcsq_pkg::OP_W-1:0] op,
                                              input logic [15:0] x, input logic [15:0] y,
                                              input logic [15:0] w, input logic [15:0] h,
                                              input logic [15:0] color, input logic lastp,
                                              input logic [lcsq_pkg::ROT_W-1:0] rot);
        lcsq_pkg::t_req r;
        r.opcode      = op;
        r.pos_x       = x;
        r.pos_y       = y;
        r.area_width  = w;
        r.area_height = h;
        r.pixel_color = color;
        r.last_pixel  = lastp;
        r.rotation    = rot;
        return r;
    endfunction

    function automatic lcsq_pkg::t_req random_req(input logic [lcsq_pkg::OP_W-1:0] op);
        return mk_req(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'($urandom), 2'($urandom));
    endfunction

    task automatic send_req(input lcsq_pkg::t_req r, output int produced);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= r.opcode;
        i_pos_x       <= r.pos_x;
        i_pos_y       <= r.pos_y;
        i_area_width  <= r.area_width;
        i_area_height <= r.area_height;
        i_pixel_color <= r.pixel_color;
        i_last_pixel  <= r.last_pixel;
        i_rotation    <= r.rotation;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        produced = expand_request(r);
    endtask

    // settle covers queued requests that give no bytes
    task automatic wait_idle(input bit settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
        if (settle) repeat (16) @(posedge i_clk);
    endtask

    task automatic set_offsets(input logic [15:0] col, input logic [15:0] row);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lcsq_pkg::CFG_COLUMN_OFFSET;
        i_cfg_data  <= col;
        @(posedge i_clk);
        col_ofs = col;
        i_cfg_index <= lcsq_pkg::CFG_ROW_OFFSET;
        i_cfg_data  <= row;
        @(posedge i_clk);
        row_ofs = row;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed_ops();
        int got;
        send_req(mk_req(lcsq_pkg::OP_SET_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000, 1'b0, 2'd0), got);
        send_req(mk_req(lcsq_pkg::OP_SET_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 1'b1, 2'd3), got);
        send_req(mk_req(lcsq_pkg::OP_DRAW_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000, 1'b0, 2'd0), got);
        send_req(mk_req(lcsq_pkg::OP_DRAW_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 1'b1, 2'd3), got);
        for (int k = 0; k < 4; k++)
            send_req(mk_req(lcsq_pkg::OP_SET_ROTATION, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                            1'b0, k[1:0]), got);
        // pixel with no open frame
        send_req(mk_req(lcsq_pkg::OP_STREAM_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hF00D,
                        1'b1, 2'd0), got);
        send_req(random_req(lcsq_pkg::OP_BEGIN_STREAM), got);
        send_req(mk_req(lcsq_pkg::OP_STREAM_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1234,
                        1'b0, 2'd0), got);
        send_req(mk_req(lcsq_pkg::OP_STREAM_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hABCD,
                        1'b1, 2'd0), got);
        send_req(random_req(lcsq_pkg::OP_STREAM_PIXEL), got);
        // reopening and abandoning a stream
        send_req(random_req(lcsq_pkg::OP_BEGIN_STREAM), got);
        send_req(random_req(lcsq_pkg::OP_BEGIN_STREAM), got);
        send_req(mk_req(lcsq_pkg::OP_STREAM_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF,
                        1'b0, 2'd0), got);
        send_req(random_req(lcsq_pkg::OP_SET_ROTATION), got);
        send_req(random_req(lcsq_pkg::OP_STREAM_PIXEL), got);
        for (int k = 5; k < 8; k++) send_req(random_req(k[2:0]), got);
        send_req(random_req(lcsq_pkg::OP_BEGIN_STREAM), got);
        send_req(random_req(lcsq_pkg::OP_DRAW_PIXEL), got);
        send_req(random_req(lcsq_pkg::OP_STREAM_PIXEL), got);
        send_req(random_req(lcsq_pkg::OP_BEGIN_STREAM), got);
        send_req(random_req(lcsq_pkg::OP_SET_WINDOW), got);
        send_req(random_req(lcsq_pkg::OP_STREAM_PIXEL), got);
    endtask

    task automatic test_offset_wrap();
        int got;
        wait_idle(1'b1);
        set_offsets(16'hFFFF, 16'hFFFF);
        send_req(mk_req(lcsq_pkg::OP_SET_WINDOW, 16'h0001, 16'h0001, 16'h0000, 16'h0001,
                        16'h0, 1'b0, 2'd0), got);
        send_req(mk_req(lcsq_pkg::OP_DRAW_PIXEL, 16'hFFFF, 16'h0002, 16'h0, 16'h0,
                        16'h8001, 1'b0, 2'd0), got);
        wait_idle(1'b1);
        set_offsets(16'h8000, 16'h7FFF);
        send_req(mk_req(lcsq_pkg::OP_SET_WINDOW, 16'h8000, 16'h8001, 16'h8000, 16'hFFFF,
                        16'h0, 1'b0, 2'd0), got);
        send_req(random_req(lcsq_pkg::OP_DRAW_PIXEL), got);
    endtask

    // done counts requests sent
    task automatic random_stream(inout int done);
        lcsq_pkg::t_req r;
        int npix;
        int got;
        if ($urandom_range(0, 1)) begin
            send_req(random_req(lcsq_pkg::OP_SET_WINDOW), got);
            done++;
        end
        send_req(random_req(lcsq_pkg::OP_BEGIN_STREAM), got);
        done++;
        npix = $urandom_range(1, 8);
        for (int k = 0; k < npix; k++) begin
            r = random_req(lcsq_pkg::OP_STREAM_PIXEL);
            // now and then leave the frame hanging
            r.last_pixel = (k == npix - 1) && ($urandom_range(0, 7) != 0);
            send_req(r, got);
            done++;
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] col_tab[5];
        logic [15:0] row_tab[5];
        int done;
        int got;
        col_tab = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000};
        row_tab = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF};
        col_tab[2] = 16'($urandom);
        row_tab[2] = 16'($urandom);
        col_tab[4] = 16'($urandom);
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle(1'b1);
            set_offsets(col_tab[ph], row_tab[ph]);
            tx_quiet = (ph == 1) || (ph == 2);
            rx_quiet = (ph == 1) || (ph == 3);
            done = 0;
            while (done < 42) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: random_stream(done);
                    5: begin
                        send_req(random_req(lcsq_pkg::OP_DRAW_PIXEL), got);
                        done++;
                    end
                    6: begin
                        send_req(random_req(lcsq_pkg::OP_SET_WINDOW), got);
                        done++;
                    end
                    7: begin
                        send_req(random_req(lcsq_pkg::OP_SET_ROTATION), got);
                        done++;
                    end
                    8: begin
                        send_req(random_req(3'($urandom_range(0, 7))), got);
                        done++;
                    end
                    default: begin
                        send_req(random_req(lcsq_pkg::OP_STREAM_PIXEL), got);
                        done++;
                    end
                endcase
                // hold the sender until the byte side has caught up
                if ($urandom_range(0, 19) == 0) wait_idle(1'b0);
            end
        end
    endtask

    initial begin : drive_out_stall
        int hold;
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 11);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_beats
        lcsq_pkg::t_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected beat: out_byte %0h", o_out_byte);
                errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, o_out_byte);
                    errors++;
                end
                if (o_is_command !== want.is_command) begin
                    $error("is_command: expected %0b, got %0b", want.is_command,
                           o_is_command);
                    errors++;
                end
                if (o_frame_start !== want.frame_start) begin
                    $error("frame_start: expected %0b, got %0b", want.frame_start,
                           o_frame_start);
                    errors++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, o_frame_end);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= '0;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_area_width  <= '0;
        i_area_height <= '0;
        i_pixel_color <= '0;
        i_last_pixel  <= 1'b0;
        i_rotation    <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_offset_wrap();
        test_random_traffic();
        wait_idle(1'b1);
        if (errors == 0)
            $display("lcd_command_byte_sequencer: match");
        else
            $display("lcd_command_byte_sequencer: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("lcd_command_byte_sequencer: mismatch");
        $finish;
    end

endmodule
